### sv/range_encoder_shift_assert.svh
// Assertion macros for the checker file of the range encoder.
`ifndef RANGE_ENCODER_SHIFT_ASSERT_SVH
`define RANGE_ENCODER_SHIFT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rngenc_pkg.sv
// Types, constants and codes shared by the range encoder modules.
package rngenc_pkg;

  localparam int RUN_COUNT_BITS_DEF = 32;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 24;
  localparam int SYM_W     = 16;
  localparam int SHIFT_W   = 5;
  localparam int REP_W     = 32;
  localparam int T_W       = 10;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [WORD_W-1:0] RANGE_START  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] RENORM_LIMIT = 32'h0080_0000;
  localparam logic [WORD_W-1:0] CARRY_BOUND  = 32'h7F80_0000;
  localparam logic [CNT_W-1:0]  FINISH_BYTES = 24'd5;
  localparam logic [BYTE_W-1:0] RUN_BYTE_NOCARRY = 8'hFF;
  localparam logic [BYTE_W-1:0] RUN_BYTE_CARRY   = 8'h00;

  // Register index, taken from paddr bit 2.
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_INIT   = 1'b1;

  // Input kind codes.
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [2:0] {
    EMIT_NONE = 3'd0,
    EMIT_HELD = 3'd1,
    EMIT_RUN  = 3'd2,
    EMIT_T    = 3'd3,
    EMIT_C2   = 3'd4,
    EMIT_C1   = 3'd5,
    EMIT_C0   = 3'd6
  } emit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      round_step;
    logic      pend_inc;
    logic      carry_from_t;
    emit_sel_t emit;
    logic      calc_r;
    logic      mul;
    logic      narrow;
    logic      fin_round;
    logic      close;
  } cmd_t;

  typedef struct packed {
    logic range_small;
    logic low_below;
    logic low_carry;
    logic pend_nz;
    logic stage_valid;
    logic out_free;
    logic kind;
  } status_t;

endpackage

### sv/range_encoder_shift.sv
// Top level of the range encoder with held-byte carry propagation.
//
//   channel  direction  transaction carries
//   s_*      in         tuser: kind; tdata: cum_base, sym_freq, shift
//   m_*      out        tdata: out_byte, repeat_res; tlast: last; tuser: stream_end
//   APB      in/out     register 0 header_byte at 0x0, register 1 initial_count at 0x4
//
// An item is taken and then handled alone. An encode item runs its renormalization rounds
// (at most three), each emitting a run of pending bytes where one is due, then forms
// both 16x32 narrowing products together and registers them before low and range
// are updated. A finish item runs the same rounds, then the final rounding and its bytes.
// Reset is synchronous and active high; it brings the coder to its start values with
// both registers at zero. A stalled result channel holds the engine at its next result.
module range_encoder_shift #(
  parameter int RUN_COUNT_BITS = rngenc_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port. pready is tied high; reads return the register.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rngenc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rngenc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rngenc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready,
  // Input items.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [15:0] cum_base, [31:16] sym_freq, [36:32] shift, [39:37] zero
  input  logic [rngenc_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] kind: 0 encode a symbol, 1 finish the stream
  input  logic                               s_tuser,
  // Result items.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] out_byte, [39:8] repeat_res
  output logic [rngenc_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                               m_tlast,
  // [0] stream_end
  output logic                               m_tuser
);
  import rngenc_pkg::*;

  // The controller sequences renormalization rounds, the narrowing multiply and the
  // finish bytes; the datapath holds all coder state and the result registers.
  cmd_t    cmd;
  status_t sts;

  rngenc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Results pass through a holding stage so that the last result of an item can be
  // marked once the item is known to produce no more; the output register then lets
  // the engine keep working while a finished result waits for the consumer.
  rngenc_dp #(
    .RUN_COUNT_BITS (RUN_COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

### sv/rngenc_ctrl.sv
// Controller state machine of the range encoder.
module rngenc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  rngenc_pkg::status_t sts,
  output rngenc_pkg::cmd_t  cmd
);
  import rngenc_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_RENORM = 12'b0000_0000_0010,
    ST_RUN    = 12'b0000_0000_0100,
    ST_MUL    = 12'b0000_0000_1000,
    ST_NARROW = 12'b0000_0001_0000,
    ST_FROUND = 12'b0000_0010_0000,
    ST_FHELD  = 12'b0000_0100_0000,
    ST_FRUN   = 12'b0000_1000_0000,
    ST_FT     = 12'b0001_0000_0000,
    ST_FC2    = 12'b0010_0000_0000,
    ST_FC1    = 12'b0100_0000_0000,
    ST_FC0    = 12'b1000_0000_0000
  } state_t;

  localparam logic [1:0] MAX_ROUNDS = 2'd3;

  state_t     state, state_next;
  logic [1:0] rounds, rounds_next;
  logic       close_pend, close_pend_next;

  assign s_tready = (state == ST_IDLE) && !close_pend;

  always_comb begin
    state_next      = state;
    rounds_next     = rounds;
    close_pend_next = close_pend;
    cmd             = '0;
    cmd.emit        = EMIT_NONE;
    case (state)
      ST_IDLE: begin
        // The last result of the previous item leaves the holding stage here.
        if (close_pend) begin
          if (!sts.stage_valid || sts.out_free) begin
            cmd.close       = 1'b1;
            close_pend_next = 1'b0;
          end
        end else if (s_tvalid) begin
          cmd.load_in = 1'b1;
          rounds_next = '0;
          state_next  = ST_RENORM;
        end
      end
      ST_RENORM: begin
        if (rounds != MAX_ROUNDS && sts.range_small) begin
          if (sts.low_below || sts.low_carry) begin
            if (sts.out_free) begin
              cmd.emit       = EMIT_HELD;
              cmd.round_step = 1'b1;
              rounds_next    = rounds + 2'd1;
              if (sts.pend_nz) begin
                state_next = ST_RUN;
              end
            end
          end else begin
            cmd.pend_inc   = 1'b1;
            cmd.round_step = 1'b1;
            rounds_next    = rounds + 2'd1;
          end
        end else if (sts.kind == KIND_FINISH) begin
          state_next = ST_FROUND;
        end else begin
          cmd.calc_r = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_RUN;
          state_next = ST_RENORM;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_NARROW;
      end
      ST_NARROW: begin
        cmd.narrow      = 1'b1;
        close_pend_next = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_FROUND: begin
        cmd.fin_round = 1'b1;
        state_next    = ST_FHELD;
      end
      ST_FHELD: begin
        if (sts.out_free) begin
          cmd.emit         = EMIT_HELD;
          cmd.carry_from_t = 1'b1;
          state_next       = sts.pend_nz ? ST_FRUN : ST_FT;
        end
      end
      ST_FRUN: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_RUN;
          state_next = ST_FT;
        end
      end
      ST_FT: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_T;
          state_next = ST_FC2;
        end
      end
      ST_FC2: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_C2;
          state_next = ST_FC1;
        end
      end
      ST_FC1: begin
        if (sts.out_free) begin
          cmd.emit   = EMIT_C1;
          state_next = ST_FC0;
        end
      end
      ST_FC0: begin
        if (sts.out_free) begin
          cmd.emit        = EMIT_C0;
          close_pend_next = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rounds     <= '0;
      close_pend <= 1'b0;
    end else begin
      state      <= state_next;
      rounds     <= rounds_next;
      close_pend <= close_pend_next;
    end
  end

endmodule

### sv/rngenc_dp.sv
// Datapath of the range encoder: coder state, multiplier, result staging and registers.
module rngenc_dp #(
  parameter int RUN_COUNT_BITS = rngenc_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rngenc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rngenc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rngenc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready,
  input  logic [rngenc_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rngenc_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                               m_tlast,
  output logic                               m_tuser,
  input  rngenc_pkg::cmd_t                   cmd,
  output rngenc_pkg::status_t                sts
);
  import rngenc_pkg::*;

  localparam logic [RUN_COUNT_BITS-1:0] PEND_MAX = '1;

  // Configuration registers.
  logic [BYTE_W-1:0] header_cfg;
  logic [CNT_W-1:0]  init_cfg;
  logic              cfg_wr;

  // Latched input item.
  logic               kind_r;
  logic [SYM_W-1:0]   base_r;
  logic [SYM_W-1:0]   freq_r;
  logic [SHIFT_W-1:0] shift_r;

  // Coder state.
  logic [WORD_W-1:0]         low_value;
  logic [WORD_W-1:0]         range_value;
  logic [BYTE_W-1:0]         held_byte;
  logic [RUN_COUNT_BITS-1:0] pending_count;
  logic [CNT_W-1:0]          byte_counter;

  // Narrowing and finishing intermediates.
  logic [WORD_W-1:0] r_val;
  logic              top_sym;
  logic [WORD_W-1:0] prod_b;
  logic [WORD_W-1:0] prod_f;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] mul_f;
  logic [SYM_W:0]    sum_bf;
  logic [T_W-1:0]    t_val;
  logic [T_W-1:0]    t_next;
  logic [CNT_W-1:0]  cnt5;

  // Pending run and result staging.
  logic [BYTE_W-1:0]         run_byte;
  logic [RUN_COUNT_BITS-1:0] run_cnt;
  logic                      carry;
  logic [BYTE_W-1:0]         em_byte;
  logic [REP_W-1:0]          em_rep;
  logic                      em_end;
  logic                      stage_valid;
  logic [BYTE_W-1:0]         stage_byte;
  logic [REP_W-1:0]          stage_rep;
  logic                      stage_end;
  logic                      out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_INIT) ? {{(APB_DATA_W-CNT_W){1'b0}}, init_cfg}
                                         : {{(APB_DATA_W-BYTE_W){1'b0}}, header_cfg};

  assign out_free = !m_tvalid || m_tready;

  assign sts.range_small = (range_value <= RENORM_LIMIT);
  assign sts.low_below   = (low_value < CARRY_BOUND);
  assign sts.low_carry   = low_value[WORD_W-1];
  assign sts.pend_nz     = (pending_count != '0);
  assign sts.stage_valid = stage_valid;
  assign sts.out_free    = out_free;
  assign sts.kind        = kind_r;

  assign sum_bf = {1'b0, base_r} + {1'b0, freq_r};
  assign mul_b  = WORD_W'(base_r) * r_val;
  assign mul_f  = WORD_W'(freq_r) * r_val;

  // Finish rounding works on the counter after the five closing bytes are counted.
  assign cnt5   = byte_counter + FINISH_BYTES;
  assign t_next = {1'b0, low_value[31:23]}
                + ((low_value[22:0] < cnt5[23:1]) ? T_W'(0) : T_W'(1));

  assign carry = cmd.carry_from_t ? (t_val[9] || t_val[8]) : low_value[WORD_W-1];

  always_comb begin
    em_byte = held_byte;
    em_rep  = REP_W'(1);
    em_end  = 1'b0;
    case (cmd.emit)
      EMIT_HELD: em_byte = carry ? (held_byte + 8'd1) : held_byte;
      EMIT_RUN: begin
        em_byte = run_byte;
        em_rep  = REP_W'(run_cnt);
      end
      EMIT_T:  em_byte = t_val[7:0];
      EMIT_C2: em_byte = byte_counter[23:16];
      EMIT_C1: em_byte = byte_counter[15:8];
      EMIT_C0: begin
        em_byte = byte_counter[7:0];
        em_end  = 1'b1;
      end
      default: em_byte = held_byte;
    endcase
  end

  // Coder state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_cfg    <= '0;
      init_cfg      <= '0;
      low_value     <= '0;
      range_value   <= RANGE_START;
      held_byte     <= '0;
      pending_count <= '0;
      byte_counter  <= '0;
      kind_r        <= KIND_ENCODE;
    end else begin
      if (cmd.load_in) begin
        kind_r <= s_tuser;
      end
      if (cmd.pend_inc && pending_count != PEND_MAX) begin
        pending_count <= pending_count + RUN_COUNT_BITS'(1);
      end
      if (cmd.emit == EMIT_HELD) begin
        pending_count <= '0;
      end
      if (cmd.round_step) begin
        range_value  <= range_value << 8;
        low_value    <= {1'b0, low_value[22:0], 8'h00};
        byte_counter <= byte_counter + CNT_W'(1);
        if (cmd.emit == EMIT_HELD) begin
          held_byte <= low_value[30:23];
        end
      end
      if (cmd.narrow) begin
        low_value   <= low_value + prod_b;
        range_value <= top_sym ? (range_value - prod_b) : prod_f;
      end
      if (cmd.fin_round) begin
        byte_counter <= cnt5;
      end
      if (cmd.close && kind_r == KIND_FINISH) begin
        low_value     <= '0;
        range_value   <= RANGE_START;
        held_byte     <= header_cfg;
        pending_count <= '0;
        byte_counter  <= init_cfg;
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_HEADER) begin
          header_cfg <= pwdata[BYTE_W-1:0];
          held_byte  <= pwdata[BYTE_W-1:0];
        end else begin
          init_cfg     <= pwdata[CNT_W-1:0];
          byte_counter <= pwdata[CNT_W-1:0];
        end
      end
    end
  end

  // Operands and intermediates.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      base_r  <= s_tdata[15:0];
      freq_r  <= s_tdata[31:16];
      shift_r <= s_tdata[36:32];
    end
    if (cmd.calc_r) begin
      r_val   <= range_value >> shift_r;
      top_sym <= ((sum_bf >> shift_r) != '0);
    end
    if (cmd.mul) begin
      prod_b <= mul_b;
      prod_f <= mul_f;
    end
    if (cmd.fin_round) begin
      t_val <= t_next;
    end
    if (cmd.emit == EMIT_HELD) begin
      run_byte <= carry ? RUN_BYTE_CARRY : RUN_BYTE_NOCARRY;
      run_cnt  <= pending_count;
    end
  end

  // One result waits in the staging register until the next one shows whether it
  // was the last of its item.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.emit != EMIT_NONE) begin
        stage_valid <= 1'b1;
        if (stage_valid) begin
          m_tvalid <= 1'b1;
        end else if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end else if (cmd.close) begin
        stage_valid <= 1'b0;
        if (stage_valid) begin
          m_tvalid <= 1'b1;
        end else if (m_tready) begin
          m_tvalid <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      stage_byte <= em_byte;
      stage_rep  <= em_rep;
      stage_end  <= em_end;
    end
    if ((cmd.emit != EMIT_NONE || cmd.close) && stage_valid) begin
      m_tdata <= {stage_rep, stage_byte};
      m_tlast <= cmd.close;
      m_tuser <= stage_end;
    end
  end

endmodule

### sv/rngenc_chk.sv
// Port checker for the range encoder and its bind to the top level.
`include "range_encoder_shift_assert.svh"

module rngenc_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rngenc_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast,
  input logic                             m_tuser
);

  // A stalled result keeps its payload.
  `RES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // The engine handles one item at a time, so ready drops after an accepted item.
  `RES_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

  // The stream end byte is always the last result of its item.
  `RES_ASSERT_NOW(a_end_last, m_tvalid && m_tuser, m_tlast, "stream end without last")

  // Every result stands for at least one byte.
  `RES_ASSERT_NOW(a_rep_nz, m_tvalid, m_tdata[39:8] != 32'd0, "result with zero repeat count")

endmodule

bind range_encoder_shift rngenc_chk u_chk (.*);
